// ----- rtl/spv_pkg.sv -----
package spv_pkg;

  localparam int FRAME_W   = 17;            // frame numbers and counts
  localparam int WHOLE_W   = 18;            // whole part of the read position
  localparam int SMP_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_PLAY   = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_PAUSE  = 3'd3;
  localparam logic [2:0] CMD_SEEK   = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;
  localparam logic [2:0] CMD_METERS = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOPING      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAN          = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER       = 3'd7;

  // Unity gain in 2.14 and the pan clamp bounds in 1.14
  localparam logic [GAIN_W-1:0]       GAIN_ONE = 16'd16384;
  localparam logic signed [GAIN_W-1:0] PAN_MAX = 16'sd16384;
  localparam logic signed [GAIN_W-1:0] PAN_MIN = -16'sd16384;

  localparam logic signed [SMP_W-1:0] SMP_MAX  = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN  = 16'sh8000;
  localparam logic [SMP_W-1:0]        PEAK_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]               command;
    logic                     restart;
    logic [15:0]              address;
    logic signed [SMP_W-1:0]  sample_left;
    logic signed [SMP_W-1:0]  sample_right;
    logic [FRAME_W-1:0]       seek_frame;
  } spv_cmd_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]  out_left;
    logic signed [SMP_W-1:0]  out_right;
    logic                     is_playing;
    logic                     has_finished;
    logic [SMP_W-1:0]         peak_left;
    logic [SMP_W-1:0]         peak_right;
    logic [FRAME_W-1:0]       position;
  } spv_res_t;

  typedef struct packed {
    logic                     valid;
    logic signed [SMP_W-1:0]  out_l;
    logic signed [SMP_W-1:0]  out_r;
    logic [SMP_W-1:0]         mag_l;
    logic [SMP_W-1:0]         mag_r;
  } spv_mix_t;

  typedef struct packed {
    logic                     done;
    logic [FRAME_W-1:0]       rem;
  } spv_div_t;

endpackage

// ----- rtl/spv_frame_mem.sv -----
module spv_frame_mem import spv_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [2*SMP_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [2*SMP_W-1:0] rdata
);

  logic [2*SMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/spv_wrap_div.sv -----
module spv_wrap_div import spv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WHOLE_W-1:0] num,
  input  logic [FRAME_W-1:0] den,
  output spv_div_t           stat
);

  localparam int CNT_W = $clog2(WHOLE_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [WHOLE_W-1:0] nsh;
  logic [WHOLE_W-1:0] rem;
  logic [FRAME_W-1:0] dq;
  logic               done;
  logic [WHOLE_W-1:0] trial;

  // Restoring remainder, one numerator bit a cycle
  assign trial = {rem[WHOLE_W-2:0], nsh[WHOLE_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WHOLE_W - 1);
        nsh  <= num;
        rem  <= '0;
        dq   <= den;
      end else if (busy) begin
        nsh <= nsh << 1;
        if (trial >= {1'b0, dq}) begin
          rem <= trial - {1'b0, dq};
        end else begin
          rem <= trial;
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem[FRAME_W-1:0];

endmodule

// ----- rtl/spv_mix.sv -----
module spv_mix import spv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [2*SMP_W-1:0]       w0,
  input  logic [2*SMP_W-1:0]       w1,
  input  logic [FRAC_BITS-1:0]     frac,
  input  logic [GAIN_W-1:0]        volume,
  input  logic signed [GAIN_W-1:0] pan,
  input  logic [GAIN_W-1:0]        master,
  output spv_mix_t                 res
);

  localparam int PW = SMP_W + 1 + FRAC_BITS + 1;

  logic [4:0] v;

  logic signed [GAIN_W-1:0] pc;
  logic [GAIN_W-1:0]        gl, gr;
  logic signed [GAIN_W:0]   gs [2];

  logic signed [SMP_W-1:0]   a0   [2];
  logic signed [PW-1:0]      prod [2];
  logic signed [2*SMP_W+1:0] lv   [2];
  logic signed [2*SMP_W+GAIN_W+1:0] lvg [2];
  logic signed [SMP_W+2:0]   pl_q [2];
  logic signed [SMP_W+GAIN_W+3:0] plm [2];
  logic [SMP_W-1:0]          mag  [2];
  logic signed [SMP_W-1:0]   o    [2];

  logic signed [SMP_W:0]      d   [2];
  logic signed [SMP_W:0]      ls  [2];
  logic signed [SMP_W+2:0]    pl  [2];
  logic [SMP_W+2:0]           ab  [2];
  logic signed [SMP_W+GAIN_W-10:0] t [2];

  always_comb begin
    pc = (pan > PAN_MAX) ? PAN_MAX : ((pan < PAN_MIN) ? PAN_MIN : pan);
    gl = (pc <= 16'sd0) ? GAIN_ONE : 16'(GAIN_ONE - pc);
    gr = (pc >= 16'sd0) ? GAIN_ONE : 16'(GAIN_ONE + pc);
    gs[0] = $signed({1'b0, gl});
    gs[1] = $signed({1'b0, gr});
    for (int k = 0; k < 2; k++) begin
      d[k]  = 17'($signed(w1[SMP_W*k +: SMP_W])) - 17'($signed(w0[SMP_W*k +: SMP_W]));
      ls[k] = 17'(a0[k]) + 17'(prod[k] >>> FRAC_BITS);
      pl[k] = 19'(lvg[k] >>> 28);
      ab[k] = pl[k][SMP_W+2] ? 19'(-pl[k]) : 19'(pl[k]);
      t[k]  = 23'(plm[k] >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], go};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      // interpolate: a + (b - a) * frac, floored
      a0[k]   <= $signed(w0[SMP_W*k +: SMP_W]);
      prod[k] <= d[k] * $signed({1'b0, frac});
      // voice gain, then pan law
      lv[k]   <= ls[k] * $signed({1'b0, volume});
      lvg[k]  <= lv[k] * gs[k];
      mag[k]  <= (ab[k] > 19'(PEAK_MAX)) ? PEAK_MAX : ab[k][SMP_W-1:0];
      plm[k]  <= pl[k] * $signed({1'b0, master});
      if (t[k] > SMP_MAX) begin
        o[k] <= SMP_MAX;
      end else if (t[k] < SMP_MIN) begin
        o[k] <= SMP_MIN;
      end else begin
        o[k] <= t[k][SMP_W-1:0];
      end
    end
  end

  // magnitudes are one stage ahead of the samples; hold them a stage
  logic [SMP_W-1:0] mag_d [2];
  always_ff @(posedge clk) begin
    mag_d[0] <= mag[0];
    mag_d[1] <= mag[1];
  end

  assign res.valid = v[4];
  assign res.out_l = o[0];
  assign res.out_r = o[1];
  assign res.mag_l = mag_d[0];
  assign res.mag_r = mag_d[1];

endmodule

// ----- rtl/sample_voice_player_core.sv -----
// Channel  Signals                        Direction  Beat
// cmd      cmd_valid, cmd_ready, cmd      in         one command item
// res      res_valid, res_ready, res      out        one result per item
// cfg      cfg_we, cfg_index, cfg_wdata   in         one register write
//
// Load, play, stop, pause, seek, read-meters, idle tick: execute, then done.
// Playing tick: two reads through the frame memory's one read port, then the
// five-stage gain pipeline; straight to done when it ends the region without
// a loop; a region wrap first waits on the one-bit-a-cycle remainder unit.
// cmd_ready is high only between items; a stalled result holds the next item at
// its done step. Synchronous reset clears flags, peaks, position; presets registers.
module sample_voice_player_core import spv_pkg::*; #(
  parameter int MAX_FRAMES = 65536,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  spv_cmd_t             cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output spv_res_t             res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW    = $clog2(MAX_FRAMES);
  localparam int POS_W = WHOLE_W + FRAC_BITS;
  localparam int SH_L  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_EXEC  = 9'b0_0000_0010,
    S_CHECK = 9'b0_0000_0100,
    S_DIV   = 9'b0_0000_1000,
    S_RD0   = 9'b0_0001_0000,
    S_RD1   = 9'b0_0010_0000,
    S_RD2   = 9'b0_0100_0000,
    S_MIX   = 9'b0_1000_0000,
    S_DONE  = 9'b1_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [FRAME_W-1:0]       frame_count, region_start, region_end;
  logic [23:0]              step_ratio;
  logic                     looping;
  logic [GAIN_W-1:0]        volume, master_volume;
  logic signed [GAIN_W-1:0] pan;

  // voice state
  spv_cmd_t           item;
  logic [POS_W-1:0]   read_position;
  logic               playing, finished;
  logic [SMP_W-1:0]   peak_l, peak_r;
  logic               seek_pending, restart_pending;
  logic [FRAME_W-1:0] seek_target;
  logic signed [SMP_W-1:0] smp_l, smp_r;
  logic [2*SMP_W-1:0] w0;

  // derived region and position values
  logic [FRAME_W-1:0] frames, start, end_c, end_eff, len, seek_clamp;
  logic [WHOLE_W-1:0] whole, i1_inc, i1;
  logic [POS_W-1:0]   pos_sel, step_fix;
  logic [POS_W+23:0]  step_wide;
  logic               past_end, wrap_ok;

  logic              mem_we;
  logic [AW-1:0]     mem_raddr;
  logic [2*SMP_W-1:0] mem_rdata;
  spv_div_t          div_stat;
  spv_mix_t          mix_res;

  always_comb begin
    frames  = (32'(frame_count) > 32'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES) : frame_count;
    start   = (region_start > frames) ? frames : region_start;
    end_c   = (region_end > frames) ? frames : region_end;
    end_eff = (end_c <= start) ? frames : end_c;
    len     = end_eff - start;
    wrap_ok = looping && (end_eff > start);
    seek_clamp = (item.seek_frame > frames) ? frames : item.seek_frame;

    // a pending seek wins over a pending restart
    if (seek_pending) begin
      pos_sel = POS_W'(seek_target) << FRAC_BITS;
    end else if (restart_pending) begin
      pos_sel = POS_W'(start) << FRAC_BITS;
    end else begin
      pos_sel = read_position;
    end

    whole    = read_position[POS_W-1:FRAC_BITS];
    past_end = whole >= {1'b0, end_eff};
    i1_inc   = whole + 1'b1;
    // clamp the upper neighbor to the last frame
    i1       = (i1_inc < {1'b0, frames}) ? i1_inc : WHOLE_W'(frames - 1'b1);

    step_wide = (POS_W + 24)'(step_ratio) << SH_L;
    step_fix  = POS_W'(step_wide >> SH_R);

    mem_raddr = (state == S_RD0) ? AW'(whole) : AW'(i1);
    mem_we    = (state == S_EXEC) && (item.command == CMD_LOAD) &&
                (32'(item.address) < 32'(MAX_FRAMES));
  end

  spv_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(item.address)),
    .wdata ({item.sample_right, item.sample_left}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spv_wrap_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start ((state == S_CHECK) && past_end && wrap_ok),
    .num   (whole - {1'b0, start}),
    .den   (len),
    .stat  (div_stat)
  );

  spv_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk    (clk),
    .rst    (rst),
    .go     (state == S_RD2),
    .w0     (w0),
    .w1     (mem_rdata),
    .frac   (read_position[FRAC_BITS-1:0]),
    .volume (volume),
    .pan    (pan),
    .master (master_volume),
    .res    (mix_res)
  );

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      frame_count     <= FRAME_W'(1);
      region_start    <= '0;
      region_end      <= '0;
      step_ratio      <= 24'd65536;
      looping         <= 1'b0;
      volume          <= GAIN_ONE;
      pan             <= '0;
      master_volume   <= GAIN_ONE;
      read_position   <= '0;
      playing         <= 1'b0;
      finished        <= 1'b0;
      peak_l          <= '0;
      peak_r          <= '0;
      seek_pending    <= 1'b0;
      restart_pending <= 1'b0;
      seek_target     <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_COUNT:  frame_count   <= cfg_wdata[FRAME_W-1:0];
          REG_REGION_START: region_start  <= cfg_wdata[FRAME_W-1:0];
          REG_REGION_END:   region_end    <= cfg_wdata[FRAME_W-1:0];
          REG_STEP_RATIO:   step_ratio    <= cfg_wdata;
          REG_LOOPING:      looping       <= cfg_wdata[0];
          REG_VOLUME:       volume        <= cfg_wdata[GAIN_W-1:0];
          REG_PAN:          pan           <= $signed(cfg_wdata[GAIN_W-1:0]);
          REG_MASTER:       master_volume <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // drop a taken beat; the done step reloads the register itself
      if (res_valid && res_ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item  <= cmd;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          smp_l <= '0;
          smp_r <= '0;
          state <= S_DONE;
          case (item.command)
            CMD_PLAY: begin
              if (item.restart) begin
                restart_pending <= 1'b1;
              end
              finished <= 1'b0;
              playing  <= 1'b1;
            end
            CMD_STOP: begin
              playing         <= 1'b0;
              restart_pending <= 1'b1;
              read_position   <= '0;
            end
            CMD_PAUSE: playing <= 1'b0;
            CMD_SEEK: begin
              seek_target  <= seek_clamp;
              seek_pending <= 1'b1;
            end
            CMD_TICK: begin
              // an idle tick changes nothing
              if (playing && (frames != '0)) begin
                read_position   <= pos_sel;
                seek_pending    <= 1'b0;
                restart_pending <= 1'b0;
                state           <= S_CHECK;
              end
            end
            default: ;
          endcase
        end

        S_CHECK: begin
          if (!past_end) begin
            state <= S_RD0;
          end else if (wrap_ok) begin
            state <= S_DIV;
          end else begin
            // end of region without loop: stop and rewind to the start
            playing       <= 1'b0;
            finished      <= 1'b1;
            read_position <= POS_W'(start) << FRAC_BITS;
            state         <= S_DONE;
          end
        end

        S_DIV: begin
          if (div_stat.done) begin
            read_position <= {WHOLE_W'(start) + WHOLE_W'(div_stat.rem),
                              read_position[FRAC_BITS-1:0]};
            state         <= S_RD0;
          end
        end

        S_RD0: state <= S_RD1;

        S_RD1: begin
          w0    <= mem_rdata;
          state <= S_RD2;
        end

        S_RD2: begin
          // the mix unit samples the fraction at this edge; advance now
          read_position <= read_position + step_fix;
          state         <= S_MIX;
        end

        S_MIX: begin
          if (mix_res.valid) begin
            smp_l <= mix_res.out_l;
            smp_r <= mix_res.out_r;
            if (mix_res.mag_l > peak_l) begin
              peak_l <= mix_res.mag_l;
            end
            if (mix_res.mag_r > peak_r) begin
              peak_r <= mix_res.mag_r;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!res_valid || res_ready) begin
            res.out_left     <= smp_l;
            res.out_right    <= smp_r;
            res.is_playing   <= playing;
            res.has_finished <= finished;
            res.peak_left    <= peak_l;
            res.peak_right   <= peak_r;
            res.position     <= read_position[FRAC_BITS +: FRAME_W];
            res_valid        <= 1'b1;
            // meters report first, then drop
            if (item.command == CMD_METERS) begin
              peak_l   <= '0;
              peak_r   <= '0;
              finished <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mem_we_load: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_EXEC) && (item.command == CMD_LOAD))
    else $error("frame write outside a load");

  a_read_in_region: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD0) |-> (whole < {1'b0, end_eff}))
    else $error("frame read at or past region end");

  a_mix_only_waiting: assert property (@(posedge clk) disable iff (rst)
    mix_res.valid |-> (state == S_MIX))
    else $error("mix result with no tick waiting");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !$past(res_valid)) |-> $past(state == S_DONE))
    else $error("result raised outside the done step");

  a_div_only_wrap: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("remainder done with no wrap pending");
`endif

endmodule

// ----- tb/sample_voice_player_core_tb.sv -----
`timescale 1ns / 1ps

module sample_voice_player_core_tb;
  import spv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEM_TARGET    = 1950;
  localparam longint MEM_FRAMES = 65536;
  // Command code that the block ignores
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // Predicted voice state, kept packed so a tick can be tried and rolled back
  typedef struct packed {
    logic [63:0] pos;
    logic [63:0] seek_to;
    logic        playing;
    logic        finished;
    logic        seek_pend;
    logic        restart_pend;
    logic [15:0] peak_l;
    logic [15:0] peak_r;
  } voice_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  spv_cmd_t             cmd       = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  spv_res_t             res;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  sample_voice_player_core dut (.*);

  // Predictor copy of the registers, at their reset values
  longint      cf_frames = 1;
  longint      cf_start  = 0;
  longint      cf_end    = 0;
  longint      cf_step   = 65536;
  logic        cf_loop   = 1'b0;
  longint      cf_vol    = 16384;
  logic [15:0] cf_pan    = '0;
  longint      cf_master = 16384;

  voice_t      voice = '0;
  logic [31:0] frame_store [0:65535];
  bit          written     [0:65535];

  spv_cmd_t    cmd_backlog_q [$];
  spv_res_t    voice_results_q [$];
  spv_res_t    want;

  int          items_posted = 0;
  int          results_seen = 0;
  int          fail_count   = 0;
  int          send_wait    = 0;
  int          recv_wait    = 0;
  int          recv_draw;
  int          quiet_cycles = 0;
  bit          send_idle    = 1'b1;
  bit          recv_idle    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_sample(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Fully random payload; the caller picks the command and any field it cares about
  function automatic spv_cmd_t rand_item(input logic [2:0] op);
    spv_cmd_t c;
    c.command      = op;
    c.restart      = $urandom_range(0, 1);
    c.address      = $urandom;
    c.sample_left  = $urandom;
    c.sample_right = $urandom;
    c.seek_frame   = $urandom_range(0, 65536);
    return c;
  endfunction

  // Apply one command to the predicted voice and build the result it produces.
  // rd_a / rd_b return the frames a playing tick reads, or -1.
  task automatic voice_advance(input spv_cmd_t c, output spv_res_t r,
                               output int rd_a, output int rd_b);
    longint frames, start, stop, span, p, i0, i1, frac, tgt, unity;
    longint a, b, l, rr, pn, gl, gr, pl, pr, al, ar, ol, orr;
    logic signed [15:0] s16;
    bit clear;
    frames = (cf_frames > MEM_FRAMES) ? MEM_FRAMES : cf_frames;
    unity = GAIN_ONE;
    ol = 0;
    orr = 0;
    rd_a = -1;
    rd_b = -1;
    clear = 1'b0;
    case (c.command)
      CMD_LOAD: begin
        frame_store[c.address] = {c.sample_right, c.sample_left};
        written[c.address] = 1'b1;
      end
      CMD_PLAY: begin
        if (c.restart) voice.restart_pend = 1'b1;
        voice.finished = 1'b0;
        voice.playing = 1'b1;
      end
      CMD_STOP: begin
        voice.playing = 1'b0;
        voice.restart_pend = 1'b1;
        voice.pos = '0;
      end
      CMD_PAUSE: voice.playing = 1'b0;
      CMD_SEEK: begin
        tgt = c.seek_frame;
        voice.seek_to = (tgt > frames) ? frames : tgt;
        voice.seek_pend = 1'b1;
      end
      CMD_TICK: begin
        if (voice.playing && frames != 0) begin
          start = (cf_start > frames) ? frames : cf_start;
          stop = (cf_end > frames) ? frames : cf_end;
          if (stop <= start) stop = frames;
          // Deferred requests land here; seek wins over restart
          if (voice.seek_pend) voice.pos = voice.seek_to << 16;
          else if (voice.restart_pend) voice.pos = start << 16;
          voice.seek_pend = 1'b0;
          voice.restart_pend = 1'b0;
          p = voice.pos;
          if (p >= (stop << 16)) begin
            span = (stop - start) << 16;
            if (cf_loop && span > 0) begin
              p = (start << 16) + (p - (start << 16)) % span;
            end else begin
              // Region end without a loop: stop, rewind, flag finished
              voice.playing = 1'b0;
              voice.finished = 1'b1;
              voice.pos = start << 16;
              p = -1;
            end
          end
          if (p >= 0) begin
            i0 = p >>> 16;
            i1 = (i0 + 1 < frames) ? i0 + 1 : frames - 1;
            frac = p & 65535;
            rd_a = i0;
            rd_b = i1;
            s16 = frame_store[i0][15:0];
            a = s16;
            s16 = frame_store[i1][15:0];
            b = s16;
            l = a + (((b - a) * frac) >>> 16);
            s16 = frame_store[i0][31:16];
            a = s16;
            s16 = frame_store[i1][31:16];
            b = s16;
            rr = a + (((b - a) * frac) >>> 16);
            voice.pos = p + cf_step;
            s16 = cf_pan;
            pn = s16;
            if (pn > PAN_MAX) pn = PAN_MAX;
            if (pn < PAN_MIN) pn = PAN_MIN;
            gl = (pn <= 0) ? unity : unity - pn;
            gr = (pn >= 0) ? unity : unity + pn;
            pl = (l * cf_vol * gl) >>> 28;
            pr = (rr * cf_vol * gr) >>> 28;
            al = (pl < 0) ? -pl : pl;
            ar = (pr < 0) ? -pr : pr;
            if (al > 65535) al = 65535;
            if (ar > 65535) ar = 65535;
            if (al > voice.peak_l) voice.peak_l = al[15:0];
            if (ar > voice.peak_r) voice.peak_r = ar[15:0];
            ol = sat_sample((pl * cf_master) >>> 14);
            orr = sat_sample((pr * cf_master) >>> 14);
          end
        end
      end
      CMD_METERS: clear = 1'b1;
      default: ;
    endcase
    r.out_left     = ol[15:0];
    r.out_right    = orr[15:0];
    r.is_playing   = voice.playing;
    r.has_finished = voice.finished;
    r.peak_left    = voice.peak_l;
    r.peak_right   = voice.peak_r;
    r.position     = voice.pos[32:16];
    // Meters report first, then clear
    if (clear) begin
      voice.peak_l = '0;
      voice.peak_r = '0;
      voice.finished = 1'b0;
    end
  endtask

  // Queue one command with its expected result. A tick that would read a
  // frame never loaded gets the missing loads queued ahead of it.
  task automatic post_item(input spv_cmd_t c);
    voice_t saved;
    spv_res_t r;
    spv_cmd_t ld;
    int ra, rb;
    saved = voice;
    voice_advance(c, r, ra, rb);
    if ((ra >= 0 && !written[ra]) || (rb >= 0 && !written[rb])) begin
      voice = saved;
      if (ra >= 0 && !written[ra]) begin
        ld = rand_item(CMD_LOAD);
        ld.address = ra[15:0];
        post_item(ld);
      end
      if (rb >= 0 && !written[rb]) begin
        ld = rand_item(CMD_LOAD);
        ld.address = rb[15:0];
        post_item(ld);
      end
      voice_advance(c, r, ra, rb);
    end
    cmd_backlog_q.push_back(c);
    voice_results_q.push_back(r);
    items_posted++;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_FRAME_COUNT:  cf_frames = value[16:0];
      REG_REGION_START: cf_start  = value[16:0];
      REG_REGION_END:   cf_end    = value[16:0];
      REG_STEP_RATIO:   cf_step   = value[23:0];
      REG_LOOPING:      cf_loop   = value[0];
      REG_VOLUME:       cf_vol    = value[15:0];
      REG_PAN:          cf_pan    = value[15:0];
      REG_MASTER:       cf_master = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_voice(input int fc, input int rs, input int re, input int stp,
                               input int lp, input int vo, input int pn, input int ms);
    set_reg(REG_FRAME_COUNT, fc);
    set_reg(REG_REGION_START, rs);
    set_reg(REG_REGION_END, re);
    set_reg(REG_STEP_RATIO, stp);
    set_reg(REG_LOOPING, lp);
    set_reg(REG_VOLUME, vo);
    set_reg(REG_PAN, pn & 32'hFFFF);
    set_reg(REG_MASTER, ms);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline go quiet
  task automatic drain();
    while (voice_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: present the next queued command, hold it until accepted, then
  // idle for the drawn gap before the following one.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_wait <= 0;
    end else if (!cmd_valid || cmd_ready) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog_q.size() != 0) begin
        cmd       <= cmd_backlog_q.pop_front();
        cmd_valid <= 1'b1;
        send_wait <= send_idle ? $urandom_range(0, 10) : 0;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation, then
  // stall the next result for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      recv_wait <= 0;
    end else if (res_valid && res_ready) begin
      results_seen++;
      if (voice_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        want = voice_results_q.pop_front();
        if (res.out_left !== want.out_left || res.out_right !== want.out_right ||
            res.is_playing !== want.is_playing || res.has_finished !== want.has_finished ||
            res.peak_left !== want.peak_left || res.peak_right !== want.peak_right ||
            res.position !== want.position) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d mismatch, expected L=%0d R=%0d play=%0b fin=%0b pk=%0d/%0d pos=%0d",
                     results_seen, want.out_left, want.out_right, want.is_playing,
                     want.has_finished, want.peak_left, want.peak_right, want.position);
            $display("result %0d mismatch, actual   L=%0d R=%0d play=%0b fin=%0b pk=%0d/%0d pos=%0d",
                     results_seen, res.out_left, res.out_right, res.is_playing,
                     res.has_finished, res.peak_left, res.peak_right, res.position);
          end
        end
      end
      recv_draw = recv_idle ? $urandom_range(0, 10) : 0;
      res_ready <= (recv_draw == 0);
      recv_wait <= recv_draw;
    end else if (res_valid) begin
      // Hold off the waiting result until the stall runs out
      if (recv_wait > 1) recv_wait <= recv_wait - 1;
      else res_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sample_voice_player_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    spv_cmd_t c;
    int fc, rs, re, stp, lp, vo, pn, ms, k, phase_no;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: eight frames, unity rate, full gains so the outputs saturate
    program_voice(8, 0, 0, 65536, 0, 32768, 0, 32768);
    c = rand_item(CMD_LOAD);
    c.address = 0;
    c.sample_left = SMP_MAX;
    c.sample_right = SMP_MIN;
    post_item(c);
    c = rand_item(CMD_LOAD);
    c.address = 1;
    c.sample_left = SMP_MIN;
    c.sample_right = SMP_MAX;
    post_item(c);
    c = rand_item(CMD_LOAD);
    c.address = 2;
    c.sample_left = '0;
    c.sample_right = '0;
    post_item(c);
    for (int i = 3; i < 8; i++) begin
      c = rand_item(CMD_LOAD);
      c.address = i;
      post_item(c);
    end
    post_item(rand_item(CMD_TICK));       // idle tick before any play
    c = rand_item(CMD_PLAY);
    c.restart = 1'b1;
    post_item(c);
    post_item(rand_item(CMD_TICK));       // full-scale left, clipped output
    post_item(rand_item(CMD_TICK));       // minus full scale, peak saturates
    post_item(rand_item(CMD_METERS));
    post_item(rand_item(CMD_PAUSE));
    post_item(rand_item(CMD_TICK));
    c = rand_item(CMD_PLAY);
    c.restart = 1'b0;
    post_item(c);
    post_item(rand_item(CMD_TICK));
    c = rand_item(CMD_SEEK);
    c.seek_frame = 5;
    post_item(c);
    post_item(rand_item(CMD_TICK));       // deferred seek lands here
    c = rand_item(CMD_SEEK);
    c.seek_frame = 65536;                 // clamps to the frame count
    post_item(c);
    post_item(rand_item(CMD_TICK));       // hits the region end and finishes
    post_item(rand_item(CMD_TICK));
    post_item(rand_item(CMD_METERS));     // reports and clears finished
    post_item(rand_item(CMD_STOP));
    c = rand_item(CMD_PLAY);
    c.restart = 1'b0;
    post_item(c);
    post_item(rand_item(CMD_TICK));       // restart requested by stop
    post_item(rand_item(CMD_UNUSED));
    drain();

    // Random phases, each with its own register setting
    phase_no = 0;
    while (items_posted < ITEM_TARGET) begin
      phase_no++;
      case (phase_no)
        1: begin
          fc = 65536; rs = 0; re = 65536; stp = 24'hFFFFFF; lp = 1;
          vo = 0; pn = -16384; ms = 0;
        end
        2: begin
          fc = 1; rs = 65536; re = 0; stp = 0; lp = 1;
          vo = 32768; pn = 16384; ms = 32768;
        end
        3: begin
          fc = 2; rs = 1; re = 2; stp = 32768; lp = 1;
          vo = 32768; pn = -16384; ms = 32768;
        end
        default: begin
          k = $urandom_range(0, 7);
          if (k == 0) fc = 1;
          else if (k == 1) fc = 65536;
          else if (k < 4) fc = $urandom_range(2, 8);
          else fc = $urandom_range(2, 64);
          rs = ($urandom_range(0, 9) == 0) ? 65536 : $urandom_range(0, fc + 2);
          k = $urandom_range(0, 9);
          if (k == 0) re = 0;
          else if (k == 1) re = 65536;
          else re = $urandom_range(0, fc + 2);
          case ($urandom_range(0, 4))
            0: stp = 65536;
            1: stp = $urandom_range(0, 24'h3FFFF);
            2: stp = $urandom & 24'hFFFFFF;
            3: stp = $urandom_range(0, 24'h1000);
            default: stp = $urandom_range(0, 24'h20000);
          endcase
          lp = $urandom_range(0, 1);
          vo = ($urandom_range(0, 5) == 0) ? 32768 : $urandom_range(0, 32768);
          pn = int'($urandom_range(0, 32768)) - 16384;
          ms = ($urandom_range(0, 5) == 0) ? 32768 : $urandom_range(0, 32768);
        end
      endcase
      program_voice(fc, rs, re, stp, lp, vo, pn, ms);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);

      // Open the phase with a restart so ticks play straight away
      c = rand_item(CMD_PLAY);
      c.restart = 1'b1;
      post_item(c);
      repeat ($urandom_range(100, 200)) begin
        k = $urandom_range(0, 99);
        if (k < 45 || k >= 86) begin
          c = rand_item(CMD_TICK);
        end else if (k < 55) begin
          c = rand_item(CMD_LOAD);
          if ($urandom_range(0, 4) != 0) c.address = $urandom_range(0, fc - 1);
        end else if (k < 65) begin
          c = rand_item(CMD_PLAY);
        end else if (k < 71) begin
          c = rand_item(CMD_SEEK);
          if ($urandom_range(0, 4) != 0) c.seek_frame = $urandom_range(0, fc + 1);
        end else if (k < 75) begin
          c = rand_item(CMD_STOP);
        end else if (k < 79) begin
          c = rand_item(CMD_PAUSE);
        end else if (k < 85) begin
          c = rand_item(CMD_METERS);
        end else begin
          c = rand_item(CMD_UNUSED);
        end
        post_item(c);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("sample_voice_player_core verification clean");
    end else begin
      $display("sample_voice_player_core verification failed");
    end
    $finish;
  end

endmodule
